FILE: src/a2r_pkg.sv
`default_nettype none

package a2r_pkg;

  // fixed-point formats: q2.30 values and wider cordic working registers
  localparam int Q_W = 32;
  localparam int X_W = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_BITS = 30;

  typedef logic signed [Q_W-1:0] q30_t;
  typedef logic signed [X_W-1:0] cx_t;

  localparam q30_t ONE_Q30 = 32'sh4000_0000;
  localparam q30_t POLE_EPS = 32'sd64;
  localparam cx_t CORDIC_GAIN_INV = 34'sd652032874;

  // arctangent of 2^-i in turns, 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // limit a working value to [-1.0, 1.0]
  function automatic q30_t clamp_q30(input cx_t v);
    if (v > cx_t'(ONE_Q30)) begin
      return ONE_Q30;
    end else if (v < -cx_t'(ONE_Q30)) begin
      return -ONE_Q30;
    end else begin
      return q30_t'(v);
    end
  endfunction

  // q2.30 product, rounded half up
  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return q30_t'(p >>> 30);
  endfunction

endpackage

`default_nettype wire

FILE: src/a2r_cordic.sv
`default_nettype none

module a2r_cordic #(
  parameter int LANES = 1,
  parameter int PW = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [LANES-1:0][31:0]         in_angle,
  input  logic [PW-1:0]                  in_payload,
  output logic                           out_valid,
  output a2r_pkg::q30_t [LANES-1:0]      out_sin,
  output a2r_pkg::q30_t [LANES-1:0]      out_cos,
  output logic [PW-1:0]                  out_payload
);
  import a2r_pkg::*;

  logic                 vld_r [CORDIC_STEPS+1];
  logic [LANES-1:0]     neg_r [CORDIC_STEPS+1];
  cx_t  [LANES-1:0]     x_r   [CORDIC_STEPS+1];
  cx_t  [LANES-1:0]     y_r   [CORDIC_STEPS+1];
  cx_t  [LANES-1:0]     z_r   [CORDIC_STEPS+1];
  logic [PW-1:0]        pay_r [CORDIC_STEPS+1];

  logic                 ovld_r;
  q30_t [LANES-1:0]     sin_r;
  q30_t [LANES-1:0]     cos_r;
  logic [PW-1:0]        opay_r;

  // input stage: fold into [-quarter, quarter) and load start vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0] <= in_payload;
      for (int l = 0; l < LANES; l++) begin
        neg_r[0][l] <= in_angle[l][31] ^ in_angle[l][30];
        x_r[0][l]   <= CORDIC_GAIN_INV;
        y_r[0][l]   <= '0;
        z_r[0][l]   <= {{(X_W-31){in_angle[l][30]}}, in_angle[l][30:0]};
      end
    end
  end

  // one rotation per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    cx_t [LANES-1:0] x_nxt;
    cx_t [LANES-1:0] y_nxt;
    cx_t [LANES-1:0] z_nxt;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (!z_r[k][l][X_W-1]) begin
          x_nxt[l] = x_r[k][l] - (y_r[k][l] >>> k);
          y_nxt[l] = y_r[k][l] + (x_r[k][l] >>> k);
          z_nxt[l] = z_r[k][l] - cx_t'(ATAN_TURNS[k]);
        end else begin
          x_nxt[l] = x_r[k][l] + (y_r[k][l] >>> k);
          y_nxt[l] = y_r[k][l] - (x_r[k][l] >>> k);
          z_nxt[l] = z_r[k][l] + cx_t'(ATAN_TURNS[k]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1]   <= x_nxt;
        y_r[k+1]   <= y_nxt;
        z_r[k+1]   <= z_nxt;
        neg_r[k+1] <= neg_r[k];
        pay_r[k+1] <= pay_r[k];
      end
    end
  end

  // output stage: clamp and undo the fold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= vld_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opay_r <= pay_r[CORDIC_STEPS];
      for (int l = 0; l < LANES; l++) begin
        if (neg_r[CORDIC_STEPS][l]) begin
          sin_r[l] <= -clamp_q30(y_r[CORDIC_STEPS][l]);
          cos_r[l] <= -clamp_q30(x_r[CORDIC_STEPS][l]);
        end else begin
          sin_r[l] <= clamp_q30(y_r[CORDIC_STEPS][l]);
          cos_r[l] <= clamp_q30(x_r[CORDIC_STEPS][l]);
        end
      end
    end
  end

  assign out_valid   = ovld_r;
  assign out_sin     = sin_r;
  assign out_cos     = cos_r;
  assign out_payload = opay_r;

endmodule

`default_nettype wire

FILE: src/a2r_search_step.sv
`default_nettype none

module a2r_search_step #(
  parameter int AB = 24,
  parameter int PW = 1,
  parameter bit IS_ASIN = 1'b1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [AB:0]   in_lo,
  input  logic signed [AB:0]   in_hi,
  input  a2r_pkg::q30_t        in_key,
  input  logic [PW-1:0]        in_payload,
  output logic                 out_valid,
  output logic signed [AB:0]   out_lo,
  output logic signed [AB:0]   out_hi,
  output a2r_pkg::q30_t        out_key,
  output logic [PW-1:0]        out_payload
);
  import a2r_pkg::*;

  localparam int W = AB + 1;
  localparam int CPW = PW + Q_W + 3 * W + 1;

  logic signed [W-1:0] span;
  logic signed [W-1:0] mid;
  logic                active;
  logic [31:0]         angle;

  logic                c_valid;
  q30_t [0:0]          c_sin;
  q30_t [0:0]          c_cos;
  logic [CPW-1:0]      c_pay;

  logic [PW-1:0]       p_payload;
  q30_t                p_key;
  logic signed [W-1:0] p_lo;
  logic signed [W-1:0] p_hi;
  logic signed [W-1:0] p_mid;
  logic                p_active;

  q30_t                val;
  logic                le;
  logic signed [W-1:0] lo_nxt;
  logic signed [W-1:0] hi_nxt;

  logic                vld_r;
  logic signed [W-1:0] lo_r;
  logic signed [W-1:0] hi_r;
  q30_t                key_r;
  logic [PW-1:0]       pay_r;

  // probe point: upper midpoint for asin, lower midpoint for acos
  always_comb begin
    span = in_hi - in_lo;
    if (IS_ASIN) begin
      mid = in_lo + ((span + W'(1)) >>> 1);
    end else begin
      mid = in_lo + (span >>> 1);
    end
    active = in_lo < in_hi;
    angle  = 32'(mid[AB-1:0]) << (32 - AB);
  end

  a2r_cordic #(
    .LANES (1),
    .PW    (CPW)
  ) u_cordic (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_angle    (angle),
    .in_payload  ({in_payload, in_key, in_lo, in_hi, mid, active}),
    .out_valid   (c_valid),
    .out_sin     (c_sin),
    .out_cos     (c_cos),
    .out_payload (c_pay)
  );

  assign {p_payload, p_key, p_lo, p_hi, p_mid, p_active} = c_pay;

  // narrow the interval by the probe result
  always_comb begin
    val    = IS_ASIN ? c_sin[0] : c_cos[0];
    le     = val <= p_key;
    lo_nxt = p_lo;
    hi_nxt = p_hi;
    if (p_active) begin
      if (IS_ASIN) begin
        if (le) begin
          lo_nxt = p_mid;
        end else begin
          hi_nxt = p_mid - W'(1);
        end
      end else begin
        if (le) begin
          hi_nxt = p_mid;
        end else begin
          lo_nxt = p_mid + W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      key_r <= p_key;
      pay_r <= p_payload;
    end
  end

  assign out_valid   = vld_r;
  assign out_lo      = lo_r;
  assign out_hi      = hi_r;
  assign out_key     = key_r;
  assign out_payload = pay_r;

endmodule

`default_nettype wire

FILE: src/a2r_divider.sv
`default_nettype none

module a2r_divider #(
  parameter int PW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [30:0]                   in_rem,
  input  logic [30:0]                   in_den,
  input  logic [PW-1:0]                 in_payload,
  output logic                          out_valid,
  output logic [a2r_pkg::DIV_BITS-1:0]  out_quo,
  output logic [PW-1:0]                 out_payload
);
  import a2r_pkg::*;

  logic                vld_r [DIV_BITS+1];
  logic [30:0]         rem_r [DIV_BITS+1];
  logic [30:0]         den_r [DIV_BITS+1];
  logic [DIV_BITS-1:0] quo_r [DIV_BITS+1];
  logic [PW-1:0]       pay_r [DIV_BITS+1];

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_rem;
      den_r[0] <= in_den;
      quo_r[0] <= '0;
      pay_r[0] <= in_payload;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_bit
    logic [31:0]         t;
    logic                take;
    logic [30:0]         rem_nxt;
    logic [DIV_BITS-1:0] quo_nxt;

    always_comb begin
      t       = {rem_r[k], 1'b0};
      take    = t >= {1'b0, den_r[k]};
      rem_nxt = take ? 31'(t - {1'b0, den_r[k]}) : t[30:0];
      quo_nxt = {quo_r[k][DIV_BITS-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= quo_nxt;
        pay_r[k+1] <= pay_r[k];
      end
    end
  end

  assign out_valid   = vld_r[DIV_BITS];
  assign out_quo     = quo_r[DIV_BITS];
  assign out_payload = pay_r[DIV_BITS];

endmodule

`default_nettype wire

FILE: src/altaz_to_radec_convert.sv
`default_nettype none

// Converts horizon coordinates (azimuth, altitude) plus local sidereal time into
// declination and right ascension for the site latitude held in the cfg register.
// Fully pipelined: one conversion per clock unless a finished result waits
// behind a held output. Its depth comes from the asin and acos binary searches:
// each of their ANGLE_BITS steps runs a full 30-stage sine/cosine CORDIC, plus a
// 30-stage divider for the hour-angle cosine. A stalled output holds its result
// while the pipeline keeps moving as long as the stage behind it is empty.
// pole_flag marks results where the hour angle is undefined (forced to zero,
// right ascension equals sidereal time). Write the latitude only while idle.
module altaz_to_radec_convert #(
  parameter int ANGLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic signed [ANGLE_BITS-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ANGLE_BITS-1:0]        in_azimuth,
  input  logic signed [ANGLE_BITS-1:0] in_altitude,
  input  logic [ANGLE_BITS-1:0]        in_sidereal_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ANGLE_BITS-1:0]        out_right_ascension,
  output logic signed [ANGLE_BITS-1:0] out_declination,
  output logic                         out_pole_flag
);
  import a2r_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int SW = AB + 1 + 3 * Q_W;
  localparam int TW = 2 * AB + 1;
  localparam int DPW = TW + 4;
  localparam int CPW = TW + 1;
  localparam logic signed [AB:0] QUARTER = (AB + 1)'(1) << (AB - 2);
  localparam logic signed [AB:0] HALF = (AB + 1)'(1) << (AB - 1);

  logic en;

  // site latitude register
  logic signed [AB-1:0] lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= '0;
    end else if (cfg_wr_en) begin
      lat_r <= cfg_wr_data;
    end
  end

  // trig of latitude, altitude and azimuth
  logic [2:0][31:0]     a_angle;
  logic                 a_valid;
  q30_t [2:0]           a_sin;
  q30_t [2:0]           a_cos;
  logic [AB-1:0]        a_sid;
  logic                 a_szp;
  logic [SW-1:0]        a_side;

  assign a_angle[0] = 32'(lat_r) << (32 - AB);
  assign a_angle[1] = 32'(in_altitude) << (32 - AB);
  assign a_angle[2] = 32'(in_azimuth) << (32 - AB);

  a2r_cordic #(
    .LANES (3),
    .PW    (AB)
  ) u_trig_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_angle    (a_angle),
    .in_payload  (in_sidereal_time),
    .out_valid   (a_valid),
    .out_sin     (a_sin),
    .out_cos     (a_cos),
    .out_payload (a_sid)
  );

  // side data: sidereal time, east-half flag, sin lat, cos lat, sin alt
  assign a_szp  = !a_sin[2][Q_W-1] && (a_sin[2] != '0);
  assign a_side = {a_sid, a_szp, a_sin[0], a_cos[0], a_sin[1]};

  // sin(dec) products
  logic          m1_vld_r;
  logic [SW-1:0] m1_side_r;
  q30_t          m1_p1_r;
  q30_t          m1_p2_r;
  q30_t          m1_cz_r;
  logic          m2_vld_r;
  logic [SW-1:0] m2_side_r;
  q30_t          m2_p1_r;
  q30_t          m2_p3_r;
  logic          m3_vld_r;
  logic [SW-1:0] m3_side_r;
  q30_t          m3_sdec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= a_valid;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_side_r <= a_side;
      m1_p1_r   <= mul_q30(a_sin[0], a_sin[1]);
      m1_p2_r   <= mul_q30(a_cos[0], a_cos[1]);
      m1_cz_r   <= a_cos[2];
      m2_side_r <= m1_side_r;
      m2_p1_r   <= m1_p1_r;
      m2_p3_r   <= mul_q30(m1_p2_r, m1_cz_r);
      m3_side_r <= m2_side_r;
      m3_sdec_r <= clamp_q30(cx_t'(m2_p1_r) + cx_t'(m2_p3_r));
    end
  end

  // asin search for declination
  logic                as_vld [AB+1];
  logic signed [AB:0]  as_lo  [AB+1];
  logic signed [AB:0]  as_hi  [AB+1];
  q30_t                as_key [AB+1];
  logic [SW-1:0]       as_pay [AB+1];

  assign as_vld[0] = m3_vld_r;
  assign as_lo[0]  = -QUARTER;
  assign as_hi[0]  = QUARTER;
  assign as_key[0] = m3_sdec_r;
  assign as_pay[0] = m3_side_r;

  for (genvar i = 0; i < AB; i++) begin : g_asin
    a2r_search_step #(
      .AB      (AB),
      .PW      (SW),
      .IS_ASIN (1'b1)
    ) u_step (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (as_vld[i]),
      .in_lo       (as_lo[i]),
      .in_hi       (as_hi[i]),
      .in_key      (as_key[i]),
      .in_payload  (as_pay[i]),
      .out_valid   (as_vld[i+1]),
      .out_lo      (as_lo[i+1]),
      .out_hi      (as_hi[i+1]),
      .out_key     (as_key[i+1]),
      .out_payload (as_pay[i+1])
    );
  end

  // trig of declination
  logic [0:0][31:0]    d_angle;
  logic                d_valid;
  q30_t [0:0]          d_sin;
  q30_t [0:0]          d_cos;
  logic [SW+AB-1:0]    d_pay;
  logic [AB-1:0]       d_sid;
  logic                d_szp;
  q30_t                d_sl;
  q30_t                d_cl;
  q30_t                d_sa;
  logic [AB-1:0]       d_dec;

  assign d_angle[0] = 32'(as_lo[AB][AB-1:0]) << (32 - AB);

  a2r_cordic #(
    .LANES (1),
    .PW    (SW + AB)
  ) u_trig_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (as_vld[AB]),
    .in_angle    (d_angle),
    .in_payload  ({as_pay[AB], as_lo[AB][AB-1:0]}),
    .out_valid   (d_valid),
    .out_sin     (d_sin),
    .out_cos     (d_cos),
    .out_payload (d_pay)
  );

  assign {d_sid, d_szp, d_sl, d_cl, d_sa, d_dec} = d_pay;

  // hour-angle numerator and denominator, pole test, sign normalization
  logic                n1_vld_r;
  q30_t                n1_pa_r;
  q30_t                n1_den_r;
  q30_t                n1_sa_r;
  logic [TW-1:0]       n1_tail_r;
  logic                n2_vld_r;
  logic signed [32:0]  n2_num_r;
  q30_t                n2_den_r;
  logic                n2_pole_r;
  logic [TW-1:0]       n2_tail_r;
  logic                n3_vld_r;
  logic signed [32:0]  n3_num_r;
  q30_t                n3_den_r;
  logic                n3_pole_r;
  logic [TW-1:0]       n3_tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_vld_r <= 1'b0;
      n2_vld_r <= 1'b0;
      n3_vld_r <= 1'b0;
    end else if (en) begin
      n1_vld_r <= d_valid;
      n2_vld_r <= n1_vld_r;
      n3_vld_r <= n2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_pa_r   <= mul_q30(d_sl, d_sin[0]);
      n1_den_r  <= mul_q30(d_cl, d_cos[0]);
      n1_sa_r   <= d_sa;
      n1_tail_r <= {d_sid, d_szp, d_dec};
      n2_num_r  <= 33'(n1_sa_r) - 33'(n1_pa_r);
      n2_den_r  <= n1_den_r;
      n2_pole_r <= (n1_den_r <= POLE_EPS) && (n1_den_r >= -POLE_EPS);
      n2_tail_r <= n1_tail_r;
      if (n2_den_r[Q_W-1]) begin
        n3_num_r <= -n2_num_r;
        n3_den_r <= -n2_den_r;
      end else begin
        n3_num_r <= n2_num_r;
        n3_den_r <= n2_den_r;
      end
      n3_pole_r <= n2_pole_r;
      n3_tail_r <= n2_tail_r;
    end
  end

  // saturation tests and magnitude for the divider
  logic               sat_hi;
  logic               sat_lo;
  logic               num_neg;
  logic signed [32:0] num_mag;

  always_comb begin
    sat_hi  = n3_num_r >= 33'(n3_den_r);
    sat_lo  = n3_num_r <= -33'(n3_den_r);
    num_neg = n3_num_r[32];
    num_mag = num_neg ? -n3_num_r : n3_num_r;
  end

  logic                div_valid;
  logic [DIV_BITS-1:0] div_quo;
  logic [DPW-1:0]      div_pay;
  logic [TW-1:0]       v_tail;
  logic                v_pole;
  logic                v_force;
  logic                v_fneg;
  logic                v_neg;

  a2r_divider #(
    .PW (DPW)
  ) u_divider (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (n3_vld_r),
    .in_rem      (num_mag[30:0]),
    .in_den      (n3_den_r[30:0]),
    .in_payload  ({n3_tail_r, n3_pole_r, sat_hi || sat_lo, !sat_hi, num_neg}),
    .out_valid   (div_valid),
    .out_quo     (div_quo),
    .out_payload (div_pay)
  );

  assign {v_tail, v_pole, v_force, v_fneg, v_neg} = div_pay;

  // cos(HA), signed and saturated
  logic          c_vld_r;
  q30_t          c_cha_r;
  logic [CPW-1:0] c_pay_r;
  q30_t          quo_q;

  assign quo_q = q30_t'({2'b00, div_quo});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_force) begin
        c_cha_r <= v_fneg ? -ONE_Q30 : ONE_Q30;
      end else begin
        c_cha_r <= v_neg ? -quo_q : quo_q;
      end
      c_pay_r <= {v_tail, v_pole};
    end
  end

  // acos search for hour angle
  logic                ac_vld [AB+1];
  logic signed [AB:0]  ac_lo  [AB+1];
  logic signed [AB:0]  ac_hi  [AB+1];
  q30_t                ac_key [AB+1];
  logic [CPW-1:0]      ac_pay [AB+1];

  assign ac_vld[0] = c_vld_r;
  assign ac_lo[0]  = '0;
  assign ac_hi[0]  = HALF;
  assign ac_key[0] = c_cha_r;
  assign ac_pay[0] = c_pay_r;

  for (genvar i = 0; i < AB; i++) begin : g_acos
    a2r_search_step #(
      .AB      (AB),
      .PW      (CPW),
      .IS_ASIN (1'b0)
    ) u_step (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (ac_vld[i]),
      .in_lo       (ac_lo[i]),
      .in_hi       (ac_hi[i]),
      .in_key      (ac_key[i]),
      .in_payload  (ac_pay[i]),
      .out_valid   (ac_vld[i+1]),
      .out_lo      (ac_lo[i+1]),
      .out_hi      (ac_hi[i+1]),
      .out_key     (ac_key[i+1]),
      .out_payload (ac_pay[i+1])
    );
  end

  // mirror hour angle, form right ascension
  logic [AB-1:0] f_sid;
  logic          f_szp;
  logic [AB-1:0] f_dec;
  logic          f_pole;
  logic [AB-1:0] f_ha;

  assign {f_sid, f_szp, f_dec, f_pole} = ac_pay[AB];

  always_comb begin
    if (f_pole) begin
      f_ha = '0;
    end else if (f_szp) begin
      f_ha = -ac_lo[AB][AB-1:0];
    end else begin
      f_ha = ac_lo[AB][AB-1:0];
    end
  end

  logic                 f_vld_r;
  logic [AB-1:0]        f_ra_r;
  logic signed [AB-1:0] f_dec_r;
  logic                 f_pole_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= ac_vld[AB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_ra_r   <= f_sid - f_ha;
      f_dec_r  <= f_dec;
      f_pole_r <= f_pole;
    end
  end

  // output register, holds while stalled
  logic                 ovld_r;
  logic [AB-1:0]        ora_r;
  logic signed [AB-1:0] odec_r;
  logic                 opole_r;
  logic                 out_load;

  assign out_load = !ovld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (out_load) begin
      ovld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ora_r   <= f_ra_r;
      odec_r  <= f_dec_r;
      opole_r <= f_pole_r;
    end
  end

  // pipeline moves unless a finished item is blocked behind a held result
  assign en       = !(f_vld_r && ovld_r && out_stall);
  assign in_stall = !en;

  assign out_valid           = ovld_r;
  assign out_right_ascension = ora_r;
  assign out_declination     = odec_r;
  assign out_pole_flag       = opole_r;

`ifndef SYNTHESIS
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (f_vld_r && ovld_r && out_stall) |-> in_stall)
    else $error("pipeline advanced into a held output");

  a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> ((odec_r >= -QUARTER) && (odec_r <= QUARTER)))
    else $error("declination outside a quarter turn");

  a_cha_range: assert property (@(posedge clk) disable iff (!rst_n)
    c_vld_r |-> ((c_cha_r <= ONE_Q30) && (c_cha_r >= -ONE_Q30)))
    else $error("hour-angle cosine outside unit range");
`endif

endmodule

`default_nettype wire

FILE: test/altaz_to_radec_convert_tb.sv
`timescale 1ns / 1ps

module altaz_to_radec_convert_tb;
  import a2r_pkg::*;

  localparam int AB = 24;
  localparam longint QUARTER = 64'sd1 <<< (AB - 2);
  localparam longint HALF = 64'sd1 <<< (AB - 1);
  localparam longint ONE = 64'sd1 <<< 30;
  localparam longint PIPE_LATENCY = 66 * AB + 104;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [AB-1:0]        ra;
    logic signed [AB-1:0] dec;
    logic                 pole;
  } radec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic signed [AB-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [AB-1:0] in_azimuth = '0;
  logic signed [AB-1:0] in_altitude = '0;
  logic [AB-1:0] in_sidereal_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [AB-1:0] out_right_ascension;
  logic signed [AB-1:0] out_declination;
  logic out_pole_flag;

  radec_t pending_radec[$];
  logic [AB-1:0] latitude = '0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  longint cycle_count = 0;

  altaz_to_radec_convert #(.ANGLE_BITS(AB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_azimuth(in_azimuth), .in_altitude(in_altitude),
    .in_sidereal_time(in_sidereal_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_right_ascension(out_right_ascension),
    .out_declination(out_declination), .out_pole_flag(out_pole_flag)
  );

  always #1 clk = ~clk;

  // rotation cordic, angle in turns (2^32 per turn), results in q2.30
  function automatic void cordic_sin_cos(input logic [31:0] t, output longint s,
                                         output longint c);
    logic [31:0] u;
    bit neg;
    longint x, y, z, nx;
    u = t;
    neg = 1'b0;
    x = 652032874;
    y = 0;
    if (((u + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      u = u + 32'h8000_0000;
      neg = 1'b1;
    end
    z = longint'($signed(u));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    x = (x > ONE) ? ONE : (x < -ONE) ? -ONE : x;
    y = (y > ONE) ? ONE : (y < -ONE) ? -ONE : y;
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  function automatic void angle_sin_cos(input longint d, output longint s, output longint c);
    logic [AB-1:0] a;
    a = d[AB-1:0];
    cordic_sin_cos({a, {(32 - AB){1'b0}}}, s, c);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic radec_t predict_radec(input logic [AB-1:0] az,
                                           input logic [AB-1:0] alt,
                                           input logic [AB-1:0] st);
    longint sl, cl, sa, ca, sz, cz, sd, cd, tmp;
    longint sdec, lo, hi, mid, num, den, cha, ha;
    radec_t r;
    angle_sin_cos(longint'(latitude), sl, cl);
    angle_sin_cos(longint'(alt), sa, ca);
    angle_sin_cos(longint'(az), sz, cz);
    sdec = qmul(sl, sa) + qmul(qmul(cl, ca), cz);
    sdec = (sdec > ONE) ? ONE : (sdec < -ONE) ? -ONE : sdec;
    // asin: largest declination whose sine does not exceed sdec
    lo = -QUARTER;
    hi = QUARTER;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      angle_sin_cos(mid, sd, tmp);
      if (sd <= sdec) lo = mid;
      else hi = mid - 1;
    end
    angle_sin_cos(lo, sd, cd);
    num = sa - qmul(sl, sd);
    den = qmul(cl, cd);
    r.pole = 1'b0;
    if (den <= 64 && den >= -64) begin
      ha = 0;
      r.pole = 1'b1;
    end else begin
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      if (num >= den) cha = ONE;
      else if (num <= -den) cha = -ONE;
      else cha = (num * ONE) / den;
      // acos: smallest hour angle whose cosine does not exceed cha
      ha = 0;
      hi = HALF;
      while (ha < hi) begin
        mid = ha + (hi - ha) / 2;
        angle_sin_cos(mid, tmp, cd);
        if (cd <= cha) hi = mid;
        else ha = mid + 1;
      end
      if (sz > 0) ha = (64'sd1 <<< AB) - ha;
    end
    tmp = longint'(st) - ha;
    r.ra = tmp[AB-1:0];
    r.dec = lo[AB-1:0];
    return r;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic [AB-1:0] az, input logic [AB-1:0] alt,
                           input logic [AB-1:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_azimuth <= az;
    in_altitude <= alt;
    in_sidereal_time <= st;
    do @(posedge clk); while (in_stall);
    pending_radec.push_back(predict_radec(az, alt, st));
    @(negedge clk);
  endtask

  // drain the pipeline, then write the latitude register
  task automatic set_latitude(input logic [AB-1:0] lat);
    in_valid <= 1'b0;
    wait (pending_radec.size() == 0);
    repeat (PIPE_LATENCY + 10) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lat;
    latitude = lat;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_directed();
    logic [AB-1:0] alts[6];
    alts = '{24'h000000, 24'h400000, 24'hC00000, 24'h7FFFFF, 24'h800000, 24'h200000};
    foreach (alts[k]) send_item(24'h000000, alts[k], 24'h000000);
    send_item(24'hFFFFFF, 24'h100000, 24'hFFFFFF);
    send_item(24'h400000, 24'h100000, 24'h123456);
    send_item(24'hC00000, 24'hF00000, 24'hABCDEF);
    send_item(24'h800000, 24'h300000, 24'h800000);
    send_item(24'h000001, 24'h000001, 24'h000001);
  endtask

  task automatic test_pole_latitude();
    send_item(24'h000000, 24'h100000, 24'h555555);
    send_item(24'h600000, 24'h400000, 24'hAAAAAA);
    send_item(24'hFFFFFF, 24'hC00000, 24'h000000);
    send_item(24'h200000, 24'h000000, 24'hFFFFFF);
  endtask

  task automatic test_random(input int count);
    logic [AB-1:0] alt;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85) alt = AB'($urandom_range(1 << (AB - 1)) - (1 << (AB - 2)));
      else alt = AB'($urandom);
      send_item(AB'($urandom), alt, AB'($urandom));
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    radec_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_radec.size() == 0) begin
        $error("unexpected result ra=%h dec=%h", out_right_ascension, out_declination);
        error_count++;
      end else begin
        exp_r = pending_radec.pop_front();
        if (out_right_ascension !== exp_r.ra) begin
          $error("right_ascension exp %h got %h", exp_r.ra, out_right_ascension);
          error_count++;
        end
        if (out_declination !== exp_r.dec) begin
          $error("declination exp %h got %h", exp_r.dec, out_declination);
          error_count++;
        end
        if (out_pole_flag !== exp_r.pole) begin
          $error("pole_flag exp %b got %b", exp_r.pole, out_pole_flag);
          error_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("altaz_to_radec_convert verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 10;
    recv_idle_pct = 47;
    test_directed();
    set_latitude(24'h400000);
    test_pole_latitude();
    set_latitude(24'hC00000);
    test_pole_latitude();
    set_latitude(24'h0C0000);
    test_random(220);
    set_latitude(24'hF40000);
    test_random(220);
    send_idle_pct = 47;
    recv_idle_pct = 10;
    set_latitude(AB'($urandom_range(1 << (AB - 1)) - (1 << (AB - 2))));
    test_random(220);
    set_latitude(AB'($urandom));
    test_random(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_latitude(24'h3FFFFF);
    test_random(220);
    set_latitude(24'h000000);
    test_random(220);
    in_valid <= 1'b0;
    wait (pending_radec.size() == 0);
    repeat (PIPE_LATENCY + 10) @(negedge clk);
    if (error_count == 0) begin
      $display("altaz_to_radec_convert verification clean");
    end else begin
      $display("altaz_to_radec_convert verification failed");
    end
    $finish;
  end

endmodule
